### sv/word_wrap_line_folder_top_macros.svh
// Assertion macros used by the checker file of the word wrap block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef WORD_WRAP_LINE_FOLDER_TOP_MACROS_SVH
`define WORD_WRAP_LINE_FOLDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWLF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WWLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/wwlf_pkg.sv
`timescale 1ns / 1ps

package wwlf_pkg;

    // Word buffer geometry.
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = ADDR_W + 1;
    localparam int COL_W        = 6;
    localparam int CMP_W        = (LEN_W > COL_W + 1) ? LEN_W : COL_W + 1;
    localparam int CHAR_W       = 8;

    // Configuration register map.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_LINE_WIDTH = 1'b0;

    // Line width limits.
    localparam logic [COL_W-1:0] WIDTH_RESET = 6'd20;
    localparam logic [COL_W-1:0] WIDTH_MIN   = 6'd2;
    localparam logic [COL_W-1:0] WIDTH_MAX   = 6'd60;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEP,
        ST_RD,
        ST_WC,
        ST_NL
    } state_t;

    typedef enum logic [1:0] {
        MODE_PLACE,
        MODE_SPLIT_ALL,
        MODE_SPLIT_ONE
    } mode_t;

    typedef enum logic [1:0] {
        EM_SPACE,
        EM_NL,
        EM_SLASH,
        EM_WORD
    } emit_sel_t;

    typedef enum logic [2:0] {
        FREE_KEEP,
        FREE_DEC,
        FREE_ZERO,
        FREE_FULL,
        FREE_PLACE
    } free_op_t;

    typedef enum logic [1:0] {
        WL_KEEP,
        WL_CLEAR,
        WL_INC,
        WL_FLAG
    } wl_op_t;

    typedef enum logic [1:0] {
        IDX_KEEP,
        IDX_CLEAR,
        IDX_INC
    } idx_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_in;
        logic      set_fin;
        logic      word_char;
        logic      set_pws;
        logic      line_reset;
        free_op_t  free_op;
        wl_op_t    wl_op;
        idx_op_t   idx_op;
        logic      ram_re;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      src_in;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic finished;
        logic eoi;
        logic is_nl;
        logic is_blank;
        logic lhc;
        logic pws;
        logic split_mode;
        logic has_word;
        logic fits;
        logic at_start;
        logic split_due;
        logic free_zero;
        logic free_one;
        logic idx_last;
        logic out_free;
    } status_t;

    // Clamp the programmed width into the supported range.
    function automatic logic [COL_W-1:0] eff_width(input logic [COL_W-1:0] lw);
        logic [COL_W-1:0] w;
        w = lw;
        if (lw < WIDTH_MIN)
        begin
            w = WIDTH_MIN;
        end
        else if (lw > WIDTH_MAX)
        begin
            w = WIDTH_MAX;
        end
        return w;
    endfunction

endpackage

### sv/wwlf_ram.sv
`timescale 1ns / 1ps

module wwlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/wwlf_ctrl.sv
`timescale 1ns / 1ps

module wwlf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  wwlf_pkg::status_t stat,
    output wwlf_pkg::cmd_t   cmd
);

    wwlf_pkg::state_t state_reg, state_next;
    wwlf_pkg::mode_t  mode_reg, mode_next;
    logic             trail_reg, trail_next;
    logic             sep_nl_reg, sep_nl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= wwlf_pkg::ST_IDLE;
            mode_reg   <= wwlf_pkg::MODE_PLACE;
            trail_reg  <= 1'b0;
            sep_nl_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            trail_reg  <= trail_next;
            sep_nl_reg <= sep_nl_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        trail_next  = trail_reg;
        sep_nl_next = sep_nl_reg;
        cmd         = '0;
        s_tready    = 1'b0;

        case (state_reg)
            wwlf_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = wwlf_pkg::ST_DECODE;
                end
            end

            wwlf_pkg::ST_DECODE:
            begin
                state_next = wwlf_pkg::ST_IDLE;
                if (stat.finished)
                begin
                    state_next = wwlf_pkg::ST_IDLE;
                end
                else if (stat.eoi || stat.is_nl || (stat.is_blank && !stat.pws))
                begin
                    // Each of these ends the current word; a buffered word is placed unless the line was empty.
                    if (stat.eoi || (stat.is_nl && !stat.lhc))
                    begin
                        cmd.set_fin = 1'b1;
                    end
                    if (stat.is_blank)
                    begin
                        cmd.set_pws = 1'b1;
                    end
                    if (stat.is_nl && !stat.lhc && !stat.eoi)
                    begin
                        // An empty input line ends the text and touches nothing else.
                        state_next = wwlf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        trail_next = stat.is_nl && !stat.eoi;
                        if (trail_next)
                        begin
                            cmd.line_reset = 1'b1;
                        end
                        if (stat.has_word)
                        begin
                            cmd.free_op = wwlf_pkg::FREE_PLACE;
                            cmd.idx_op  = wwlf_pkg::IDX_CLEAR;
                            mode_next   = wwlf_pkg::MODE_PLACE;
                            sep_nl_next = !stat.fits;
                            if (!stat.fits || !stat.at_start)
                            begin
                                state_next = wwlf_pkg::ST_SEP;
                            end
                            else
                            begin
                                state_next = wwlf_pkg::ST_RD;
                            end
                        end
                        else
                        begin
                            cmd.wl_op  = wwlf_pkg::WL_CLEAR;
                            state_next = trail_next ? wwlf_pkg::ST_NL : wwlf_pkg::ST_IDLE;
                        end
                    end
                end
                else if (!stat.is_blank && !stat.is_nl)
                begin
                    cmd.word_char = 1'b1;
                    if (stat.split_mode)
                    begin
                        mode_next  = wwlf_pkg::MODE_SPLIT_ONE;
                        state_next = wwlf_pkg::ST_WC;
                    end
                    else
                    begin
                        cmd.wl_op = wwlf_pkg::WL_INC;
                        if (stat.split_due)
                        begin
                            mode_next   = wwlf_pkg::MODE_SPLIT_ALL;
                            cmd.idx_op  = wwlf_pkg::IDX_CLEAR;
                            state_next  = wwlf_pkg::ST_RD;
                        end
                    end
                end
            end

            wwlf_pkg::ST_SEP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = sep_nl_reg ? wwlf_pkg::EM_NL : wwlf_pkg::EM_SPACE;
                    state_next   = wwlf_pkg::ST_RD;
                end
            end

            wwlf_pkg::ST_RD:
            begin
                cmd.ram_re = 1'b1;
                state_next = wwlf_pkg::ST_WC;
            end

            wwlf_pkg::ST_WC:
            begin
                cmd.src_in = (mode_reg == wwlf_pkg::MODE_SPLIT_ONE);
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (mode_reg != wwlf_pkg::MODE_PLACE && stat.free_zero)
                    begin
                        cmd.emit_sel = wwlf_pkg::EM_NL;
                        cmd.free_op  = wwlf_pkg::FREE_FULL;
                    end
                    else if (mode_reg != wwlf_pkg::MODE_PLACE && stat.free_one)
                    begin
                        // The slash leaves no column, so a newline follows next.
                        cmd.emit_sel = wwlf_pkg::EM_SLASH;
                        cmd.free_op  = wwlf_pkg::FREE_ZERO;
                    end
                    else
                    begin
                        cmd.emit_sel = wwlf_pkg::EM_WORD;
                        case (mode_reg)
                            wwlf_pkg::MODE_PLACE:
                            begin
                                cmd.emit_last = stat.idx_last && !trail_reg;
                                if (stat.idx_last)
                                begin
                                    cmd.wl_op  = wwlf_pkg::WL_CLEAR;
                                    state_next = trail_reg ? wwlf_pkg::ST_NL
                                                           : wwlf_pkg::ST_IDLE;
                                end
                                else
                                begin
                                    cmd.idx_op = wwlf_pkg::IDX_INC;
                                    state_next = wwlf_pkg::ST_RD;
                                end
                            end
                            wwlf_pkg::MODE_SPLIT_ALL:
                            begin
                                cmd.free_op   = wwlf_pkg::FREE_DEC;
                                cmd.emit_last = stat.idx_last;
                                if (stat.idx_last)
                                begin
                                    cmd.wl_op  = wwlf_pkg::WL_FLAG;
                                    state_next = wwlf_pkg::ST_IDLE;
                                end
                                else
                                begin
                                    cmd.idx_op = wwlf_pkg::IDX_INC;
                                    state_next = wwlf_pkg::ST_RD;
                                end
                            end
                            default:
                            begin
                                cmd.free_op   = wwlf_pkg::FREE_DEC;
                                cmd.emit_last = 1'b1;
                                state_next    = wwlf_pkg::ST_IDLE;
                            end
                        endcase
                    end
                end
            end

            wwlf_pkg::ST_NL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = wwlf_pkg::EM_NL;
                    cmd.emit_last = 1'b1;
                    cmd.free_op   = wwlf_pkg::FREE_FULL;
                    state_next    = wwlf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wwlf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/wwlf_dpath.sv
`timescale 1ns / 1ps

module wwlf_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wwlf_pkg::cmd_t                     cmd,
    output wwlf_pkg::status_t                  stat,
    input  logic [wwlf_pkg::CHAR_W-1:0]        in_char,
    input  logic                               in_eoi,
    input  logic                               cfg_we,
    input  logic [wwlf_pkg::COL_W-1:0]         cfg_wdata,
    output logic [wwlf_pkg::COL_W-1:0]         line_width,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [wwlf_pkg::CHAR_W-1:0]        out_char,
    output logic                               out_last
);

    localparam int CMP_W = wwlf_pkg::CMP_W;
    localparam int LEN_W = wwlf_pkg::LEN_W;
    localparam int COL_W = wwlf_pkg::COL_W;
    localparam int ADDR_W = wwlf_pkg::ADDR_W;
    localparam int CHAR_W = wwlf_pkg::CHAR_W;

    logic [COL_W-1:0]  lw_reg, lw_next;
    logic [COL_W-1:0]  free_reg, free_next;
    logic [LEN_W-1:0]  wl_reg, wl_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              pws_reg, pws_next;
    logic              lhc_reg, lhc_next;
    logic              fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_eoi_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;

    logic [COL_W-1:0]  w;
    logic [CMP_W-1:0]  w_ext, free_ext, wl_ext, idx_ext, depth_ext, limit;
    logic [CMP_W-1:0]  fit_free, nofit_free, sep_cost;
    logic [COL_W-1:0]  place_free;
    logic [CHAR_W-1:0] ram_rdata, word_char, emit_char;
    logic              ram_we;

    assign w         = wwlf_pkg::eff_width(lw_reg);
    assign w_ext     = CMP_W'(w);
    assign free_ext  = CMP_W'(free_reg);
    assign wl_ext    = CMP_W'(wl_reg);
    assign idx_ext   = CMP_W'(idx_reg);
    assign depth_ext = CMP_W'(wwlf_pkg::BUFFER_DEPTH);
    assign limit     = (w_ext < depth_ext) ? w_ext : depth_ext;

    // Column budget after a buffered word is placed.
    assign sep_cost   = (free_reg == w) ? '0 : CMP_W'(1);
    assign fit_free   = free_ext - sep_cost - wl_ext;
    assign nofit_free = (w_ext > wl_ext) ? (w_ext - wl_ext) : '0;
    assign place_free = stat.fits ? fit_free[COL_W-1:0] : nofit_free[COL_W-1:0];

    always_comb
    begin
        stat            = '0;
        stat.finished   = fin_reg;
        stat.eoi        = in_eoi_reg;
        stat.is_nl      = (in_char_reg == wwlf_pkg::CH_NL);
        stat.is_blank   = (in_char_reg == wwlf_pkg::CH_SPACE)
                          || (in_char_reg == wwlf_pkg::CH_TAB);
        stat.lhc        = lhc_reg;
        stat.pws        = pws_reg;
        stat.split_mode = (wl_reg == LEN_W'(wwlf_pkg::BUFFER_DEPTH));
        stat.has_word   = (wl_reg != '0) && (wl_reg < LEN_W'(wwlf_pkg::BUFFER_DEPTH));
        stat.fits       = (wl_ext < free_ext);
        stat.at_start   = (free_reg == w);
        stat.split_due  = ((wl_ext + CMP_W'(1)) >= limit);
        stat.free_zero  = (free_reg == '0);
        stat.free_one   = (free_reg == COL_W'(1));
        stat.idx_last   = (idx_ext == (wl_ext - CMP_W'(1)));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign ram_we = (cmd.wl_op == wwlf_pkg::WL_INC)
                    && (wl_reg < LEN_W'(wwlf_pkg::BUFFER_DEPTH));

    wwlf_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (wwlf_pkg::BUFFER_DEPTH)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wl_reg[ADDR_W-1:0]),
        .wdata (in_char_reg),
        .re    (cmd.ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign word_char = cmd.src_in ? in_char_reg : ram_rdata;

    always_comb
    begin
        case (cmd.emit_sel)
            wwlf_pkg::EM_SPACE: emit_char = wwlf_pkg::CH_SPACE;
            wwlf_pkg::EM_NL:    emit_char = wwlf_pkg::CH_NL;
            wwlf_pkg::EM_SLASH: emit_char = wwlf_pkg::CH_SLASH;
            default:            emit_char = word_char;
        endcase
    end

    always_comb
    begin
        lw_next        = lw_reg;
        free_next      = free_reg;
        wl_next        = wl_reg;
        idx_next       = idx_reg;
        pws_next       = pws_reg;
        lhc_next       = lhc_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;

        if (cfg_we)
        begin
            // A new width drops the buffered word and starts a fresh line.
            lw_next   = cfg_wdata;
            free_next = wwlf_pkg::eff_width(cfg_wdata);
            wl_next   = '0;
            pws_next  = 1'b1;
            lhc_next  = 1'b0;
        end
        else
        begin
            if (cmd.set_fin)
            begin
                fin_next = 1'b1;
            end
            if (cmd.word_char)
            begin
                lhc_next = 1'b1;
                pws_next = 1'b0;
            end
            if (cmd.set_pws)
            begin
                pws_next = 1'b1;
            end
            if (cmd.line_reset)
            begin
                pws_next = 1'b1;
                lhc_next = 1'b0;
            end

            case (cmd.free_op)
                wwlf_pkg::FREE_DEC:   free_next = free_reg - COL_W'(1);
                wwlf_pkg::FREE_ZERO:  free_next = '0;
                wwlf_pkg::FREE_FULL:  free_next = w;
                wwlf_pkg::FREE_PLACE: free_next = place_free;
                default:              free_next = free_reg;
            endcase

            case (cmd.wl_op)
                wwlf_pkg::WL_CLEAR: wl_next = '0;
                wwlf_pkg::WL_INC:   wl_next = wl_reg + LEN_W'(1);
                wwlf_pkg::WL_FLAG:  wl_next = LEN_W'(wwlf_pkg::BUFFER_DEPTH);
                default:            wl_next = wl_reg;
            endcase

            case (cmd.idx_op)
                wwlf_pkg::IDX_CLEAR: idx_next = '0;
                wwlf_pkg::IDX_INC:   idx_next = idx_reg + ADDR_W'(1);
                default:             idx_next = idx_reg;
            endcase
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg        <= wwlf_pkg::WIDTH_RESET;
            free_reg      <= wwlf_pkg::eff_width(wwlf_pkg::WIDTH_RESET);
            wl_reg        <= '0;
            idx_reg       <= '0;
            pws_reg       <= 1'b1;
            lhc_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lw_reg        <= lw_next;
            free_reg      <= free_next;
            wl_reg        <= wl_next;
            idx_reg       <= idx_next;
            pws_reg       <= pws_next;
            lhc_reg       <= lhc_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_char_reg <= in_char;
            in_eoi_reg  <= in_eoi;
        end
        if (cmd.emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign line_width = lw_reg;
    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_last   = out_last_reg;

endmodule

### sv/word_wrap_line_folder_top.sv
`timescale 1ns / 1ps

// Word wrap line folder. Text enters one byte per item on the s_ stream and
// leaves folded to the programmed line width on the m_ stream; m_tlast marks
// the final output byte caused by one input item, and s_tlast marks end of
// text. A plain byte is accepted and then decoded. When an item places or
// splits a buffered word, each byte comes out of the word RAM, whose read is
// registered, with a read state followed by an emit state; a stalled m_tready
// holds the emitting states. A new item is taken only after the previous one
// has handed all of its bytes to the output register, while that register may
// still be waiting for the sink. The word RAM needs no clearing pass after
// reset, since only entries written for the current word are read back.
// Register line_width sits at byte address 0 and may only be written while
// the block is idle; writing it drops any buffered word and starts a new
// line, but a text that has already ended stays ended until reset.
module word_wrap_line_folder_top (
    input  logic                          clk,
    input  logic                          rst_n,

    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] in_char
    input  logic                          s_tlast,   // end_of_input

    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_char
    output logic                          m_tlast,   // last

    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wwlf_pkg::PADDR_W-1:0]  paddr,
    input  logic [wwlf_pkg::PDATA_W-1:0]  pwdata,
    output logic [wwlf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    wwlf_pkg::cmd_t    cmd;
    wwlf_pkg::status_t stat;
    logic              cfg_hit;
    logic              cfg_we;
    logic [wwlf_pkg::COL_W-1:0] line_width;

    // The register index is the address divided by four; only index zero
    // exists, so writes elsewhere are dropped and reads return zero.
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[wwlf_pkg::PADDR_W-1] == wwlf_pkg::REG_LINE_WIDTH);
    assign cfg_we  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? wwlf_pkg::PDATA_W'(line_width) : '0;

    // The controller sequences each item: decode, then any separator, the
    // buffered bytes one read at a time, line breaks, and a closing newline.
    wwlf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the line state, the word RAM and the output register.
    wwlf_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_char    (s_tdata),
        .in_eoi     (s_tlast),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[wwlf_pkg::COL_W-1:0]),
        .line_width (line_width),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

### sv/wwlf_checker.sv
`timescale 1ns / 1ps

`include "word_wrap_line_folder_top_macros.svh"

module wwlf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled output item holds its value.
    `WWLF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // An accepted input item keeps the block busy at least while it is decoded.
    `WWLF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken again right after an accept")

    // New output only comes from work on an accepted item.
    `WWLF_ASSERT_SAME(a_emit_while_busy, $rose(m_tvalid), $past(!s_tready), "output appeared while the block was idle")

    // While an item's results are incomplete, no new input is taken.
    `WWLF_ASSERT_SAME(a_no_accept_mid_item, m_tvalid && !m_tlast, !s_tready, "input ready before the last result of an item")

endmodule

bind word_wrap_line_folder_top wwlf_checker u_wwlf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
